>>> src/serial_mouse_packet_decoder_unit_assert.svh
// Assertion macros for the serial mouse packet decoder.
`ifndef SERIAL_MOUSE_PACKET_DECODER_UNIT_ASSERT_SVH
`define SERIAL_MOUSE_PACKET_DECODER_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define SMPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SMPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/smpd_pkg.sv
// Types, constants and helper functions shared by the mouse packet decoder.
package smpd_pkg;

  localparam logic [4:0] SyncTag    = 5'b10000;  // top bits of a sync byte
  localparam logic [2:0] MiddleOnly = 3'b101;    // active-low: only middle down
  localparam logic [2:0] LastPos    = 3'd4;      // position of the fifth byte
  localparam logic [7:0] DeltaMin   = 8'h81;     // -127
  localparam logic [7:0] DeltaMax   = 8'h7f;     // +127
  localparam logic [7:0] DeltaNeg   = 8'h80;     // -128

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } packet_t;

  typedef struct packed {
    logic [2:0] buttons;
    logic [7:0] move_x;
    logic [7:0] move_y;
    logic [7:0] wheel_v;
    logic [7:0] wheel_h;
    logic       last_of_run;
  } report_t;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } outq_stat_t;

  function automatic logic [7:0] clamp_delta(input logic [7:0] b);
    return (b == DeltaNeg) ? DeltaMin : b;
  endfunction

  function automatic logic [7:0] neg_delta(input logic [7:0] b);
    return (b == DeltaNeg) ? DeltaMax : (~b + 8'd1);
  endfunction

endpackage

>>> src/smpd_collect.sv
// Packet collector: sync detection, byte position and stored packet bytes.
module smpd_collect (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  output smpd_pkg::packet_t pkt_o,
  output logic [2:0]      pos_o,
  output logic            fire_o
);
  import smpd_pkg::*;

  logic [2:0] pos_q, pos_d;
  logic [7:0] bytes_q [4];
  logic       drop, store;

  assign drop   = (pos_q == 3'd0) && (rx_byte_i[7:3] != SyncTag);
  assign store  = accept_i && !drop && (pos_q != LastPos);
  assign fire_o = accept_i && (pos_q == LastPos);

  always_comb begin
    pos_d = pos_q;
    if (fire_o) begin
      pos_d = 3'd0;
    end else if (store) begin
      pos_d = pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 3'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      bytes_q[pos_q[1:0]] <= rx_byte_i;
    end
  end

  assign pkt_o = '{b0: bytes_q[0], b1: bytes_q[1], b2: bytes_q[2], b3: bytes_q[3]};
  assign pos_o = pos_q;

endmodule

>>> src/smpd_decode.sv
// Report decoder: builds one or two reports from a complete packet.
module smpd_decode (
  input  smpd_pkg::packet_t pkt_i,
  input  logic [7:0]        b4_i,
  input  logic              scroll_en_i,
  output smpd_pkg::report_t rep0_o,
  output smpd_pkg::report_t rep1_o,
  output logic              second_o
);
  import smpd_pkg::*;

  logic       scroll;
  logic [2:0] btn;

  assign second_o = (pkt_i.b3 != 8'd0) || (b4_i != 8'd0);
  assign scroll   = scroll_en_i && (pkt_i.b0[2:0] == MiddleOnly) &&
                    ((pkt_i.b1 != 8'd0) || (pkt_i.b2 != 8'd0));

  // sync byte: bit2 left, bit1 middle, bit0 right, all active low
  assign btn = {~pkt_i.b0[1], ~pkt_i.b0[0], ~pkt_i.b0[2]};

  always_comb begin
    if (scroll) begin
      rep0_o = '{buttons: 3'd0, move_x: 8'd0, move_y: 8'd0,
                 wheel_v: clamp_delta(pkt_i.b2), wheel_h: clamp_delta(pkt_i.b1),
                 last_of_run: !second_o};
      rep1_o = '{buttons: 3'd0, move_x: 8'd0, move_y: 8'd0,
                 wheel_v: clamp_delta(b4_i), wheel_h: clamp_delta(pkt_i.b3),
                 last_of_run: 1'b1};
    end else begin
      rep0_o = '{buttons: btn, move_x: clamp_delta(pkt_i.b1),
                 move_y: neg_delta(pkt_i.b2), wheel_v: 8'd0, wheel_h: 8'd0,
                 last_of_run: !second_o};
      rep1_o = '{buttons: btn, move_x: clamp_delta(pkt_i.b3),
                 move_y: neg_delta(b4_i), wheel_v: 8'd0, wheel_h: 8'd0,
                 last_of_run: 1'b1};
    end
  end

endmodule

>>> src/smpd_outq.sv
// Two-slot result register: head slot drives the outputs, second slot waits.
module smpd_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  smpd_pkg::report_t   rep0_i,
  input  smpd_pkg::report_t   rep1_i,
  input  logic                second_i,
  input  logic                out_ready_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  output smpd_pkg::report_t   head_o,
  output smpd_pkg::outq_stat_t stat_o
);
  import smpd_pkg::*;

  report_t a_q, a_d, b_q, b_d;
  logic    a_valid_q, a_valid_d, b_valid_q, b_valid_d;
  logic    pop;

  assign pop        = a_valid_q && out_ready_i;
  assign can_load_o = !b_valid_q && (!a_valid_q || out_ready_i);

  always_comb begin
    a_d       = a_q;
    b_d       = b_q;
    a_valid_d = a_valid_q;
    b_valid_d = b_valid_q;
    if (load_i) begin
      a_d       = rep0_i;
      a_valid_d = 1'b1;
      b_d       = rep1_i;
      b_valid_d = second_i;
    end else if (pop) begin
      if (b_valid_q) begin
        a_d       = b_q;
        b_valid_d = 1'b0;
      end else begin
        a_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign out_valid_o = a_valid_q;
  assign head_o      = a_q;
  assign stat_o      = '{a_valid: a_valid_q, b_valid: b_valid_q};

endmodule

>>> src/serial_mouse_packet_decoder_unit.sv
// Top level of the serial mouse packet decoder.
//
// Input channel (in_valid_i/in_ready_o, rx_byte_i): one received serial
// byte per item. Until a sync byte (top five bits 10000) arrives, bytes
// are dropped; the sync byte and the next four bytes form a packet.
// Output channel (out_valid_o/out_ready_i): one pointer or wheel report
// per item, last_of_run_o marking the final report of a packet.
// Config: cfg_we_i writes cfg_wdata_i into the center-scroll enable;
// write it only while the block is idle.
// Latency: the fifth byte of a packet is decoded in the cycle it is
// accepted; its first report is valid on the next cycle.
// Throughput: one byte per cycle, back to back, except when the fifth byte
// of a packet stalls; only that byte needs room in the report slots.
// Stall: reports wait in a two-slot register; in_ready_o falls only at the
// fifth byte of a packet, when those slots cannot take a further two
// reports.
// Reset: byte position returns to zero (waiting for sync), the report
// slots empty and center scroll is off.
module serial_mouse_packet_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] buttons_o,
  output logic signed [7:0] move_x_o,
  output logic signed [7:0] move_y_o,
  output logic signed [7:0] wheel_v_o,
  output logic signed [7:0] wheel_h_o,
  output logic       last_of_run_o
);
  import smpd_pkg::*;

  logic       scroll_en_q;
  logic       accept, fire, second, can_load;
  logic [2:0] pos;
  packet_t    pkt;
  report_t    rep0, rep1, head;
  outq_stat_t q_stat;

  // center-scroll enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      scroll_en_q <= cfg_wdata_i;
    end
  end

  // only the fifth byte loads reports, so only it waits for slot room
  assign in_ready_o = (pos != LastPos) || can_load;
  assign accept     = in_valid_i && in_ready_o;

  smpd_collect u_collect (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .pkt_o     (pkt),
    .pos_o     (pos),
    .fire_o    (fire)
  );

  // fifth byte goes straight from the port into the decoder
  smpd_decode u_decode (
    .pkt_i       (pkt),
    .b4_i        (rx_byte_i),
    .scroll_en_i (scroll_en_q),
    .rep0_o      (rep0),
    .rep1_o      (rep1),
    .second_o    (second)
  );

  smpd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .rep0_i      (rep0),
    .rep1_i      (rep1),
    .second_i    (second),
    .out_ready_i (out_ready_i),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  assign buttons_o     = head.buttons;
  assign move_x_o      = head.move_x;
  assign move_y_o      = head.move_y;
  assign wheel_v_o     = head.wheel_v;
  assign wheel_h_o     = head.wheel_h;
  assign last_of_run_o = head.last_of_run;

  `include "serial_mouse_packet_decoder_unit_assert.svh"

  `SMPD_ASSERT(a_pos_range, pos <= LastPos, "byte position out of range")
  `SMPD_ASSERT(a_slot_order, q_stat.b_valid |-> q_stat.a_valid, "second slot without head")
  `SMPD_ASSERT(a_pair_held, (fire && second) |=> q_stat.b_valid, "second report not held")
  `SMPD_ASSERT(a_not_last, (out_valid_o && !last_of_run_o) |-> q_stat.b_valid, "lost report")
  `SMPD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o || rst_ni, "valid during reset")

endmodule

>>> tb/mouse_report_checker.sv
// Scoreboard for the mouse packet decoder: predicts reports from accepted bytes and checks them.
module mouse_report_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [2:0]        buttons_i,
  input  logic [7:0]        move_x_i,
  input  logic [7:0]        move_y_i,
  input  logic [7:0]        wheel_v_i,
  input  logic [7:0]        wheel_h_i,
  input  logic              last_of_run_i,
  output int unsigned       fail_count_o,
  output int unsigned       reports_pending_o,
  output logic              packet_open_o
);
  import smpd_pkg::*;

  logic        scroll_on;
  logic [2:0]  byte_pos;
  logic [7:0]  held [4];
  report_t     awaited_reports[$];
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  // -128 is pulled up to -127, everything else passes
  function automatic logic [7:0] clamp127(input logic [7:0] b);
    if ($signed(b) < -8'sd127) return DeltaMin;
    return b;
  endfunction

  // y is flipped; -128 saturates to +127
  function automatic logic [7:0] flip_y(input logic [7:0] b);
    logic signed [8:0] v;
    v = -$signed({b[7], b});
    if (v > 9'sd127) v = 9'sd127;
    return v[7:0];
  endfunction

  task automatic decode_serial_byte(input logic [7:0] rx);
    logic    second;
    logic    scroll;
    report_t r;
    if (byte_pos == 3'd0 && rx[7:3] != SyncTag) return;
    if (byte_pos < LastPos) begin
      held[byte_pos[1:0]] = rx;
      byte_pos = byte_pos + 3'd1;
      return;
    end
    byte_pos = 3'd0;
    second = (held[3] != 8'h00) || (rx != 8'h00);
    scroll = scroll_on && held[0][2:0] == MiddleOnly
             && (held[1] != 8'h00 || held[2] != 8'h00);
    r = '0;
    r.last_of_run = !second;
    if (scroll) begin
      r.wheel_h = clamp127(held[1]);
      r.wheel_v = clamp127(held[2]);
    end else begin
      // sync byte is active low: bit2 left, bit1 middle, bit0 right
      r.buttons = {~held[0][1], ~held[0][0], ~held[0][2]};
      r.move_x  = clamp127(held[1]);
      r.move_y  = flip_y(held[2]);
    end
    awaited_reports.push_back(r);
    if (second) begin
      r.last_of_run = 1'b1;
      if (scroll) begin
        r.wheel_h = clamp127(held[3]);
        r.wheel_v = clamp127(rx);
      end else begin
        r.move_x = clamp127(held[3]);
        r.move_y = flip_y(rx);
      end
      awaited_reports.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_report();
    report_t want;
    if (awaited_reports.size() == 0) begin
      $error("unexpected report: buttons=0x%0h move_x=0x%02h move_y=0x%02h", buttons_i,
             move_x_i, move_y_i);
      mismatches++;
      return;
    end
    want = awaited_reports.pop_front();
    check_field("buttons", 8'(want.buttons), 8'(buttons_i));
    check_field("move_x", want.move_x, move_x_i);
    check_field("move_y", want.move_y, move_y_i);
    check_field("wheel_v", want.wheel_v, wheel_v_i);
    check_field("wheel_h", want.wheel_h, wheel_h_i);
    check_field("last_of_run", 8'(want.last_of_run), 8'(last_of_run_i));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_on = 1'b0;
      byte_pos  = 3'd0;
      for (int i = 0; i < 4; i++) held[i] = 8'h00;
      awaited_reports.delete();
      packet_open_o     <= 1'b0;
      reports_pending_o <= 0;
    end else begin
      // a report of this edge always stems from an earlier byte
      if (out_valid_i && out_ready_i) check_report();
      // a byte of this edge still sees the old scroll setting
      if (in_valid_i && in_ready_i) decode_serial_byte(rx_byte_i);
      if (cfg_we_i) scroll_on = cfg_wdata_i;
      packet_open_o     <= (byte_pos != 3'd0);
      reports_pending_o <= awaited_reports.size();
    end
  end

endmodule

>>> tb/tb.sv
// Testbench top for the serial mouse packet decoder: byte stimulus, back-pressure and verdict.
module tb;
  import smpd_pkg::*;

  // Far above the slowest legal run of roughly 650 bytes with stalls.
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseBytes  = 200;
  localparam int unsigned HoldCycles  = 120;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_wdata_i = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [7:0]        rx_byte_i   = 8'h00;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [2:0]        buttons_o;
  logic signed [7:0] move_x_o;
  logic signed [7:0] move_y_o;
  logic signed [7:0] wheel_v_o;
  logic signed [7:0] wheel_h_o;
  logic              last_of_run_o;

  int unsigned fail_count;
  int unsigned reports_pending;
  logic        packet_open;
  int unsigned cycle_count    = 0;
  int unsigned bytes_sent     = 0;
  bit          sender_idles   = 1'b1;
  bit          receiver_idles = 1'b1;
  bit          hold_armed     = 1'b0;

  always #2 clk_i = ~clk_i;

  serial_mouse_packet_decoder_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .buttons_o     (buttons_o),
    .move_x_o      (move_x_o),
    .move_y_o      (move_y_o),
    .wheel_v_o     (wheel_v_o),
    .wheel_h_o     (wheel_h_o),
    .last_of_run_o (last_of_run_o)
  );

  mouse_report_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .buttons_i         (buttons_o),
    .move_x_i          (move_x_o),
    .move_y_i          (move_y_o),
    .wheel_v_i         (wheel_v_o),
    .wheel_h_i         (wheel_h_o),
    .last_of_run_i     (last_of_run_o),
    .fail_count_o      (fail_count),
    .reports_pending_o (reports_pending),
    .packet_open_o     (packet_open)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL serial_mouse_packet_decoder_unit");
      $finish;
    end
  end

  // Report sink. Ready drops at random when idling is on; once armed, it
  // holds off for a long stretch so the report slots fill and the decoder
  // has to stall its byte input.
  initial begin : report_sink
    forever begin
      @(posedge clk_i);
      if (hold_armed) begin
        hold_armed = 1'b0;
        for (int n = 0; n < HoldCycles; n++) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end
      out_ready_i <= !(receiver_idles && $urandom_range(99) < 26);
    end
  end

  // Offer one byte and wait until it is taken. Valid stays up afterwards so
  // back-to-back bytes need no gap; an idle spell lowers it first.
  task automatic send_byte(input logic [7:0] b);
    while (sender_idles && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3,
                             input logic [7:0] b4);
    send_byte(b0);
    send_byte(b1);
    send_byte(b2);
    send_byte(b3);
    send_byte(b4);
  endtask

  // Deltas lean on the clamp and negate corners.
  function automatic logic [7:0] pick_delta();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return DeltaNeg;
      2:       return DeltaMax;
      3:       return DeltaMin;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed packets with random content; some stray bytes,
  // which may themselves look like a sync and shift the framing.
  task automatic send_random_traffic();
    logic [2:0] keys;
    logic [7:0] d1, d2, d3, d4;
    if ($urandom_range(99) < 12) begin
      send_byte(8'($urandom));
      return;
    end
    keys = ($urandom_range(99) < 35) ? MiddleOnly : 3'($urandom);
    d1 = pick_delta();
    d2 = pick_delta();
    d3 = pick_delta();
    d4 = pick_delta();
    if ($urandom_range(99) < 10) begin
      d1 = 8'h00;
      d2 = 8'h00;
    end
    if ($urandom_range(99) < 40) begin
      d3 = 8'h00;
      d4 = 8'h00;
    end
    send_packet({SyncTag, keys}, d1, d2, d3, d4);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_random_traffic();
  endtask

  // Finish any open packet with zero bytes, then wait for every report.
  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (packet_open) begin
      send_byte(8'h00);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (reports_pending != 0) @(posedge clk_i);
    // reports pass through a register after decode; the extra wait covers it
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_scroll(input logic enable);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= enable;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Center scroll off (reset value). Stray bytes before sync, then
    // -128 deltas on one report and a second report with -128 on both.
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h88);
    send_packet(8'h80, DeltaNeg, DeltaNeg, 8'h00, 8'h00);
    send_packet(8'h87, DeltaMax, DeltaMax, DeltaNeg, DeltaNeg);
    drain();

    // Center scroll on: wheel packet with clamping on its first report, then
    // a middle-only packet with zero first deltas that stays a pointer report.
    write_scroll(1'b1);
    send_packet({SyncTag, MiddleOnly}, DeltaNeg, DeltaNeg, DeltaMax, DeltaMin);
    send_packet({SyncTag, MiddleOnly}, 8'h00, 8'h00, 8'h05, 8'h00);
    drain();

    // Random traffic, both sides idling.
    run_random(PhaseBytes);
    drain();

    // Scroll off, no idling at all, and one long receiver hold-off.
    write_scroll(1'b0);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    hold_armed     = 1'b1;
    run_random(PhaseBytes);
    drain();

    // Scroll back on with idling again.
    write_scroll(1'b1);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    run_random(PhaseBytes);
    drain();

    if (fail_count == 0) begin
      $display("PASS serial_mouse_packet_decoder_unit");
    end else begin
      $display("FAIL serial_mouse_packet_decoder_unit");
    end
    $finish;
  end

endmodule
